@@ design/mfmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_pkg
// Types, constants and the low-pass update shared by the feedback decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

   // frame and result widths
   localparam int COUNT_W   = 13;
   localparam int RPM_W     = 16;
   localparam int CUR_W     = 16;
   localparam int TEMP_W    = 8;
   localparam int SINGLE_W  = 25;
   localparam int TOTAL_W   = 41;
   localparam int SPEED_W   = 27;
   localparam int CURF_W    = 24;
   localparam int ALPHA_W   = 17;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 128;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_ALPHA   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_ALPHA = 1'b1;

   localparam logic [ALPHA_W-1:0] SPEED_ALPHA_RESET   = 17'd55706;
   localparam logic [ALPHA_W-1:0] CURRENT_ALPHA_RESET = 17'd58982;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE           = 17'h10000;

   localparam logic [COUNT_W:0]  HALF_TURN    = 14'd4096;
   localparam logic [11:0]       COUNT_TO_Q16 = 12'd2880;

   localparam logic signed [SPEED_W-1:0] SPEED_MIN   = -27'sd50331648;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX   = 27'sd50331392;
   localparam logic signed [SPEED_W-1:0] CURRENT_MIN = -27'sd8388608;
   localparam logic signed [SPEED_W-1:0] CURRENT_MAX = 27'sd8388352;

   // turn step codes decided by the front end
   localparam logic [1:0] TURN_NONE = 2'd0;
   localparam logic [1:0] TURN_DEC  = 2'd1;
   localparam logic [1:0] TURN_INC  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]                  turn_step;
      logic [SINGLE_W-1:0]         single_angle;
      logic signed [SPEED_W-1:0]   speed_sample;
      logic signed [CURF_W-1:0]    current_sample;
      logic [TEMP_W-1:0]           temperature;
   } entry_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [ALPHA_W-1:0]     data;
   } csr_write_type;

   // one first-order low-pass step: state + round(alpha * (sample - state) / 65536)
   function automatic logic signed [SPEED_W-1:0] ema_update(
      input logic signed [SPEED_W-1:0] state,
      input logic signed [SPEED_W-1:0] sample,
      input logic [ALPHA_W-1:0]        alpha,
      input logic signed [SPEED_W-1:0] lo,
      input logic signed [SPEED_W-1:0] hi
   );
      logic [ALPHA_W-1:0]          a;
      logic signed [SPEED_W:0]     diff;
      logic signed [45:0]          prod;
      logic signed [45:0]          rnd;
      logic signed [29:0]          step;
      logic signed [30:0]          sum;
      logic signed [30:0]          lo_ext;
      logic signed [30:0]          hi_ext;
      logic signed [SPEED_W-1:0]   res;
      a      = alpha[ALPHA_W-1] ? ALPHA_ONE : alpha;
      diff   = $signed({sample[SPEED_W-1], sample}) - $signed({state[SPEED_W-1], state});
      prod   = $signed({1'b0, a}) * diff;
      rnd    = prod + 46'sd32768;
      step   = rnd[45:16];
      sum    = $signed({step[29], step}) + $signed({{4{state[SPEED_W-1]}}, state});
      lo_ext = $signed({{4{lo[SPEED_W-1]}}, lo});
      hi_ext = $signed({{4{hi[SPEED_W-1]}}, hi});
      if (sum < lo_ext) begin
         res = lo;
      end else if (sum > hi_ext) begin
         res = hi;
      end else begin
         res = sum[SPEED_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ design/mfmd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_front
// Accepts feedback frames, classifies the count jump and scales the samples.
// ----------------------------------------------------------------------------
module mfmd_front
   import mfmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // encoder_count, speed_rpm, current_raw, temperature_raw, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  q_full,
   output logic                       q_push,
   output entry_type                  q_entry
);

   logic [COUNT_W-1:0]        prev_count_ff;
   logic [COUNT_W-1:0]        prev_count_in;
   logic [COUNT_W-1:0]        count;
   logic signed [RPM_W-1:0]   rpm;
   logic signed [CUR_W-1:0]   cur;
   logic [COUNT_W:0]          count_x;
   logic [COUNT_W:0]          prev_x;
   logic signed [SPEED_W-1:0] rpm_ext;

   assign count   = req_tdata[12:0];
   assign rpm     = req_tdata[28:13];
   assign cur     = req_tdata[44:29];
   assign count_x = {1'b0, count};
   assign prev_x  = {1'b0, prev_count_ff};
   assign rpm_ext = {{(SPEED_W-RPM_W){rpm[RPM_W-1]}}, rpm};

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      // jump up by more than half a turn is a turn backwards
      if (count_x > prev_x + HALF_TURN) begin
         q_entry.turn_step = TURN_DEC;
      end else if (prev_x > count_x + HALF_TURN) begin
         q_entry.turn_step = TURN_INC;
      end else begin
         q_entry.turn_step = TURN_NONE;
      end
      q_entry.single_angle   = SINGLE_W'(count) * SINGLE_W'(COUNT_TO_Q16);
      // rpm * 1536 gives deg/s with 8 fraction bits
      q_entry.speed_sample   = (rpm_ext <<< 10) + (rpm_ext <<< 9);
      q_entry.current_sample = {cur, 8'b0};
      q_entry.temperature    = req_tdata[52:45];
   end

   assign prev_count_in = q_push ? count : prev_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
      end else begin
         prev_count_ff <= prev_count_in;
      end
   end

endmodule
`default_nettype wire

@@ design/mfmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_queue
// Short queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module mfmd_queue
   import mfmd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           valid,
   output entry_type      head
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   logic              do_pop;

   assign full   = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid  = (count_ff != '0);
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ design/mfmd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_back
// Filter and turn counter update, multi-turn angle and the result register.
// ----------------------------------------------------------------------------
module mfmd_back
   import mfmd_pkg::*;
#(
   parameter int TURN_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csr_write_type         csr,
   input  wire logic                  q_valid,
   input  wire entry_type             q_entry,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // single_turn_angle, multi_turn_angle, speed_filtered, current_filtered,
   // temperature, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int TOT_W = (TURN_BITS + 26 > TOTAL_W) ? TURN_BITS + 26 : TOTAL_W;
   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
   localparam logic [TURN_BITS-1:0]        TURN_ONE = {{(TURN_BITS-1){1'b0}}, 1'b1};

   logic [ALPHA_W-1:0]          speed_alpha_ff;
   logic [ALPHA_W-1:0]          speed_alpha_in;
   logic [ALPHA_W-1:0]          current_alpha_ff;
   logic [ALPHA_W-1:0]          current_alpha_in;
   logic signed [TURN_BITS-1:0] turn_ff;
   logic signed [TURN_BITS-1:0] turn_in;
   logic signed [SPEED_W-1:0]   speed_ff;
   logic signed [SPEED_W-1:0]   speed_in;
   logic signed [CURF_W-1:0]    current_ff;
   logic signed [CURF_W-1:0]    current_in;
   logic signed [SPEED_W-1:0]   current_new;
   logic                        valid_ff;
   logic                        valid_in;
   logic [SINGLE_W-1:0]         single_ff;
   logic [TOTAL_W-1:0]          total_ff;
   logic [TOTAL_W-1:0]          total_in;
   logic [TEMP_W-1:0]           temp_ff;
   logic [TOT_W-1:0]            turn_ext;
   logic [TOT_W-1:0]            turn45;
   logic [TOT_W-1:0]            total_full;

   assign q_pop = q_valid && (!valid_ff || rsp_tready);

   always_comb begin
      speed_alpha_in   = speed_alpha_ff;
      current_alpha_in = current_alpha_ff;
      if (csr.we) begin
         case (csr.index)
            CSR_SPEED_ALPHA:   speed_alpha_in   = csr.data;
            CSR_CURRENT_ALPHA: current_alpha_in = csr.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (q_entry.turn_step)
         TURN_DEC: turn_in = (turn_ff != TURN_MIN) ? turn_ff - TURN_ONE : turn_ff;
         TURN_INC: turn_in = (turn_ff != TURN_MAX) ? turn_ff + TURN_ONE : turn_ff;
         default:  turn_in = turn_ff;
      endcase
   end

   // 360 * 65536 = 45 << 19
   assign turn_ext   = {{(TOT_W-TURN_BITS){turn_in[TURN_BITS-1]}}, turn_in};
   assign turn45     = (turn_ext << 5) + (turn_ext << 3) + (turn_ext << 2) + turn_ext;
   assign total_full = (turn45 << 19) + {{(TOT_W-SINGLE_W){1'b0}}, q_entry.single_angle};
   assign total_in   = total_full[TOTAL_W-1:0];

   assign speed_in    = ema_update(speed_ff, q_entry.speed_sample, speed_alpha_ff,
                                   SPEED_MIN, SPEED_MAX);
   assign current_new = ema_update({{(SPEED_W-CURF_W){current_ff[CURF_W-1]}}, current_ff},
                                   {{(SPEED_W-CURF_W){q_entry.current_sample[CURF_W-1]}},
                                    q_entry.current_sample},
                                   current_alpha_ff, CURRENT_MIN, CURRENT_MAX);
   assign current_in  = current_new[CURF_W-1:0];

   assign valid_in = q_pop ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_alpha_ff   <= SPEED_ALPHA_RESET;
         current_alpha_ff <= CURRENT_ALPHA_RESET;
         turn_ff          <= '0;
         speed_ff         <= '0;
         current_ff       <= '0;
         valid_ff         <= 1'b0;
      end else begin
         speed_alpha_ff   <= speed_alpha_in;
         current_alpha_ff <= current_alpha_in;
         valid_ff         <= valid_in;
         if (q_pop) begin
            turn_ff    <= turn_in;
            speed_ff   <= speed_in;
            current_ff <= current_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         single_ff <= q_entry.single_angle;
         total_ff  <= total_in;
         temp_ff   <= q_entry.temperature;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b0, temp_ff, current_ff, speed_ff, total_ff, single_ff};

endmodule
`default_nettype wire

@@ design/motor_feedback_multiturn_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder
// Multi-turn encoder unwrap with low-pass filtered speed and current.
// ----------------------------------------------------------------------------
// Takes one feedback frame per cycle and returns one result per frame, in
// order, through the queue and then the result register. Unless rsp stalls,
// the sustained rate is one item per cycle, set by the back end's filter
// update (subtract, 18x28 multiply, round and clamp) feeding its own state.
// A two-entry queue sits between the classifying front end and the back end,
// so req_tready only drops once that queue is full behind a stalled rsp. The
// user must write alpha registers via the csr port while no item is in flight;
// the block does not enforce it. No clearing pass is needed after reset.
module motor_feedback_multiturn_decoder
   import mfmd_pkg::*;
#(
   parameter int TURN_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // encoder_count, speed_rpm, current_raw, temperature_raw, zero pad
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // single_turn_angle, multi_turn_angle, speed_filtered, current_filtered,
   // temperature, zero pad
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ALPHA_W-1:0]     csr_wdata
);

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_valid;
   entry_type     push_entry;
   entry_type     head_entry;
   csr_write_type csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   mfmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   mfmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (head_entry)
   );

   mfmd_back #(
      .TURN_BITS (TURN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ design/mfmd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_checker
// Port-level checks on the feedback decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mfmd_checker
   import mfmd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // reset leaves no result pending and the queue open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

   // single-turn angle is a multiple of 64 in q16
   a_single_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] == 6'b0)
      else $error("single-turn angle off grid");

   // whole turns only touch bits from 19 up, so total and single agree below
   a_total_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[43:25] == rsp_tdata[18:0])
      else $error("total angle low bits differ from single-turn angle");

endmodule

bind motor_feedback_multiturn_decoder mfmd_checker u_checker (.*);
`default_nettype wire

@@ dv/tb_motor_feedback_multiturn_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_feedback_multiturn_decoder
// Self-checking bench for the multi-turn feedback decoder.
// ----------------------------------------------------------------------------
// Frames go in on req and results come back on rsp, one per frame, in order.
// A behavioural decoder in the bench unwraps the encoder count into turns,
// runs both low-pass filters and predicts each result field. A short table
// of hand-picked frames comes first, then random frames over several filter
// weight settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_motor_feedback_multiturn_decoder;

   localparam int TURN_BITS      = 16;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 4;

   localparam longint HALF_TURN_COUNTS = 4096;
   localparam longint COUNT_Q16        = 2880;
   localparam longint TURN_Q16         = 360 * 65536;
   localparam longint RPM_TO_Q8        = 1536;
   localparam longint CURRENT_TO_Q8    = 256;
   localparam longint FULL_WEIGHT      = 65536;
   localparam longint SPEED_LO         = -50331648;
   localparam longint SPEED_HI         = 50331392;
   localparam longint CURRENT_LO       = -8388608;
   localparam longint CURRENT_HI       = 8388352;
   localparam longint TURN_HI          = (longint'(1) <<< (TURN_BITS - 1)) - 1;
   localparam longint TURN_LO          = -TURN_HI - 1;

   // req_tdata layout
   localparam int RPM_LSB  = mfmd_pkg::COUNT_W;
   localparam int ICUR_LSB = RPM_LSB + mfmd_pkg::RPM_W;
   localparam int ITMP_LSB = ICUR_LSB + mfmd_pkg::CUR_W;
   // rsp_tdata layout
   localparam int TOT_LSB  = mfmd_pkg::SINGLE_W;
   localparam int SPD_LSB  = TOT_LSB + mfmd_pkg::TOTAL_W;
   localparam int OCUR_LSB = SPD_LSB + mfmd_pkg::SPEED_W;
   localparam int OTMP_LSB = OCUR_LSB + mfmd_pkg::CURF_W;

   typedef struct packed {
      logic [12:0]        count;
      logic signed [15:0] rpm;
      logic signed [15:0] current;
      logic [7:0]         temperature;
   } frame_type;

   typedef struct packed {
      logic [24:0]        single_angle;
      logic signed [40:0] multi_angle;
      logic signed [26:0] speed;
      logic signed [23:0] current;
      logic [7:0]         temperature;
   } result_type;

   typedef struct packed {
      frame_type  frame;
      logic       known;
      result_type want;
   } row_type;

   localparam logic [15:0] EDGE16 [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   // first rows run from reset with the filters at rest, so the angles can be typed in
   localparam row_type DIRECTED_ROWS [18] = '{
      // first frame above half a turn counts one turn back
      '{'{13'd4097, 16'sd0, 16'sd0, 8'hA5}, 1'b1,
        '{25'd11799360, -41'sd11793600, 27'sd0, 24'sd0, 8'hA5}},
      '{'{13'd0, 16'sd0, 16'sd0, 8'd0}, 1'b1, '{25'd0, 41'sd0, 27'sd0, 24'sd0, 8'd0}},
      '{'{13'd8191, 16'sd0, 16'sd0, 8'd255}, 1'b1,
        '{25'd23590080, -41'sd2880, 27'sd0, 24'sd0, 8'd255}},
      // drop of exactly half a turn keeps the turn count
      '{'{13'd4095, 16'sd0, 16'sd0, 8'd0}, 1'b1,
        '{25'd11793600, -41'sd11799360, 27'sd0, 24'sd0, 8'd0}},
      '{'{13'd8191, 16'sd0, 16'sd0, 8'd1}, 1'b1,
        '{25'd23590080, -41'sd2880, 27'sd0, 24'sd0, 8'd1}},
      '{'{13'd0, 16'sd0, 16'sd0, 8'd0}, 1'b1, '{25'd0, 41'sd0, 27'sd0, 24'sd0, 8'd0}},
      '{'{13'd4096, 16'sd0, 16'sd0, 8'd0}, 1'b1,
        '{25'd11796480, 41'sd11796480, 27'sd0, 24'sd0, 8'd0}},
      '{'{13'd0, 16'sd0, 16'sd0, 8'd0}, 1'b1, '{25'd0, 41'sd0, 27'sd0, 24'sd0, 8'd0}},
      '{'{13'd8191, 16'h7FFF, 16'h7FFF, 8'd255}, 1'b0, '0},
      '{'{13'd8191, 16'h7FFF, 16'h7FFF, 8'd255}, 1'b0, '0},
      '{'{13'd0, 16'h8000, 16'h8000, 8'd0}, 1'b0, '0},
      '{'{13'd0, 16'h8000, 16'h8000, 8'd0}, 1'b0, '0},
      '{'{13'h1555, 16'h5555, 16'hAAAA, 8'hAA}, 1'b0, '0},
      '{'{13'h0AAA, 16'hAAAA, 16'h5555, 8'h55}, 1'b0, '0},
      '{'{13'h1FFF, 16'h0001, 16'hFFFF, 8'hF0}, 1'b0, '0},
      '{'{13'h0000, 16'hFFFF, 16'h0001, 8'h0F}, 1'b0, '0},
      '{'{13'd100, 16'h0000, 16'h0000, 8'd25}, 1'b0, '0},
      '{'{13'd6000, 16'd3000, 16'hF000, 8'd90}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [mfmd_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [mfmd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [mfmd_pkg::CSR_INDEX_W-1:0] csr_index = mfmd_pkg::CSR_SPEED_ALPHA;
   logic [mfmd_pkg::ALPHA_W-1:0] csr_wdata = '0;

   // decoder state as the bench sees it
   logic [16:0]                  model_speed_alpha;
   logic [16:0]                  model_current_alpha;
   logic [12:0]                  model_prev_count;
   logic signed [TURN_BITS-1:0]  model_turns;
   logic signed [26:0]           model_speed;
   logic signed [24:0]           model_current;

   row_type    offered_rows[$];
   result_type results_due[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      holdoff_asked = 0;
   int      holdoff_given = 0;
   int      hold_left = 0;
   logic [12:0] walk_count = '0;

   motor_feedback_multiturn_decoder #(
      .TURN_BITS(TURN_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic longint smooth(longint state, longint sample, logic [16:0] weight,
                                     longint lo, longint hi);
      longint a;
      longint nxt;
      a   = (weight > 17'd65536) ? FULL_WEIGHT : longint'(weight);
      nxt = state + ((a * (sample - state) + 32768) >>> 16);
      if (nxt < lo) nxt = lo;
      if (nxt > hi) nxt = hi;
      return nxt;
   endfunction

   // filters first, then the turn unwrap; the result shows the updated state
   function automatic result_type decode_frame(frame_type f);
      longint     delta;
      longint     total;
      result_type r;
      model_speed = 27'(smooth(longint'(model_speed), longint'(f.rpm) * RPM_TO_Q8,
                               model_speed_alpha, SPEED_LO, SPEED_HI));
      model_current = 25'(smooth(longint'(model_current), longint'(f.current) * CURRENT_TO_Q8,
                                 model_current_alpha, CURRENT_LO, CURRENT_HI));
      delta = longint'(f.count) - longint'(model_prev_count);
      if (delta > HALF_TURN_COUNTS) begin
         if (model_turns > TURN_LO) model_turns = model_turns - 1'b1;
      end else if (delta < -HALF_TURN_COUNTS) begin
         if (model_turns < TURN_HI) model_turns = model_turns + 1'b1;
      end
      model_prev_count = f.count;
      r.single_angle = 25'(longint'(f.count) * COUNT_Q16);
      total          = longint'(model_turns) * TURN_Q16 + longint'(r.single_angle);
      r.multi_angle  = 41'(total);
      r.speed        = model_speed;
      r.current      = 24'(model_current);
      r.temperature  = f.temperature;
      return r;
   endfunction

   // mostly a rotor turning smoothly, some half-turn strides and some noise
   function automatic frame_type random_frame();
      frame_type f;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         walk_count = walk_count + 13'($urandom_range(1200)) - 13'd600;
      end else if (pick < 80) begin
         if ($urandom_range(1)) walk_count = walk_count + 13'($urandom_range(4200, 4000));
         else walk_count = walk_count - 13'($urandom_range(4200, 4000));
      end else if (pick < 85) begin
         walk_count = walk_count + 13'd4096;
      end else begin
         walk_count = 13'($urandom);
      end
      f.count = walk_count;
      case ($urandom_range(3))
         0, 1: f.rpm = 16'($urandom);
         2: f.rpm = 16'($urandom_range(400)) - 16'd200;
         default: f.rpm = EDGE16[$urandom_range(3)];
      endcase
      case ($urandom_range(3))
         0, 1: f.current = 16'($urandom);
         2: f.current = 16'($urandom_range(400)) - 16'd200;
         default: f.current = EDGE16[$urandom_range(3)];
      endcase
      f.temperature = 8'($urandom);
      return f;
   endfunction

   task automatic offer(row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      offered_rows.push_back(row);
      req_tvalid <= 1'b1;
      req_tdata  <= {row.frame.temperature, row.frame.current, row.frame.rpm, row.frame.count};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0 || offered_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int n_items, logic [16:0] speed_weight, logic [16:0] current_weight,
                            int send_pct, int recv_pct, bit hold);
      row_type r;
      settle();
      csr_we    <= 1'b1;
      csr_index <= mfmd_pkg::CSR_SPEED_ALPHA;
      csr_wdata <= speed_weight;
      @(posedge clock);
      csr_index <= mfmd_pkg::CSR_CURRENT_ALPHA;
      csr_wdata <= current_weight;
      @(posedge clock);
      csr_we <= 1'b0;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (hold) holdoff_asked++;
      r.known = 1'b0;
      r.want  = '0;
      repeat (n_items) begin
         r.frame = random_frame();
         offer(r);
      end
   endtask

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (holdoff_asked != holdoff_given) begin
            holdoff_given++;
            hold_left = HOLDOFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      frame_type  seen;
      result_type got;
      result_type want;
      row_type    row;
      bit         moved;
      moved = 1'b0;
      if (reset) begin
         model_speed_alpha   = mfmd_pkg::SPEED_ALPHA_RESET;
         model_current_alpha = mfmd_pkg::CURRENT_ALPHA_RESET;
         model_prev_count    = '0;
         model_turns         = '0;
         model_speed         = '0;
         model_current       = '0;
         idle_cycles         = 0;
      end else begin
         if (csr_we) begin
            moved = 1'b1;
            case (csr_index)
               mfmd_pkg::CSR_SPEED_ALPHA: model_speed_alpha = csr_wdata;
               mfmd_pkg::CSR_CURRENT_ALPHA: model_current_alpha = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            seen.count       = req_tdata[0 +: mfmd_pkg::COUNT_W];
            seen.rpm         = req_tdata[RPM_LSB +: mfmd_pkg::RPM_W];
            seen.current     = req_tdata[ICUR_LSB +: mfmd_pkg::CUR_W];
            seen.temperature = req_tdata[ITMP_LSB +: mfmd_pkg::TEMP_W];
            row  = offered_rows.pop_front();
            want = decode_frame(seen);
            results_due.push_back(row.known ? row.want : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got.single_angle = rsp_tdata[0 +: mfmd_pkg::SINGLE_W];
            got.multi_angle  = rsp_tdata[TOT_LSB +: mfmd_pkg::TOTAL_W];
            got.speed        = rsp_tdata[SPD_LSB +: mfmd_pkg::SPEED_W];
            got.current      = rsp_tdata[OCUR_LSB +: mfmd_pkg::CURF_W];
            got.temperature  = rsp_tdata[OTMP_LSB +: mfmd_pkg::TEMP_W];
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: result with no item pending, expected none got %h", $time,
                        rsp_tdata);
            end else begin
               want = results_due.pop_front();
               if (got.single_angle !== want.single_angle) begin
                  mismatches++;
                  $display("%0t: single_turn_angle expected %0d got %0d", $time,
                           want.single_angle, got.single_angle);
               end
               if (got.multi_angle !== want.multi_angle) begin
                  mismatches++;
                  $display("%0t: multi_turn_angle expected %0d got %0d", $time,
                           want.multi_angle, got.multi_angle);
               end
               if (got.speed !== want.speed) begin
                  mismatches++;
                  $display("%0t: speed_filtered expected %0d got %0d", $time,
                           want.speed, got.speed);
               end
               if (got.current !== want.current) begin
                  mismatches++;
                  $display("%0t: current_filtered expected %0d got %0d", $time,
                           want.current, got.current);
               end
               if (got.temperature !== want.temperature) begin
                  mismatches++;
                  $display("%0t: temperature expected %0d got %0d", $time,
                           want.temperature, got.temperature);
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i]) offer(DIRECTED_ROWS[i]);
      run_phase(300, 17'd55706, 17'd58982, 0, 0, 1'b0);
      run_phase(300, 17'd0, 17'd0, 68, 0, 1'b0);
      run_phase(300, 17'd65536, 17'd65536, 0, 68, 1'b1);
      run_phase(300, 17'd131071, 17'd65537, 10, 10, 1'b0);
      run_phase(300, 17'd1, 17'd65535, 0, 0, 1'b0);
      run_phase(300, 17'($urandom_range(131071)), 17'($urandom_range(131071)), 10, 10, 1'b0);
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
